### hw/rtl/kmp_stream_matcher_unit_assert.svh
// Assertion macros shared by the stream matcher RTL.
`ifndef KMP_STREAM_MATCHER_UNIT_ASSERT_SVH
`define KMP_STREAM_MATCHER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define KMPSM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kmpsm: assertion failed");
// Checked property that also holds during reset.
`define KMPSM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("kmpsm: assertion failed");
`else
`define KMPSM_ASSERT(lbl, clk, rstn, prop)
`define KMPSM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hw/rtl/kmpsm_pkg.sv
// Types and constants of the KMP stream matcher.
package kmpsm_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PLEN_W  = 7;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned COUNT_W = 16;

  // Longest text the position counter may track before it holds.
  localparam longint unsigned MAX_TEXT_LENGTH = 64'd65536;
  localparam longint unsigned POS_LIMIT =
    (MAX_TEXT_LENGTH > 64'd65536) ? 64'd65536 : MAX_TEXT_LENGTH;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_LIMIT - 64'd1);

  // Request codes on the input channel.
  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  // One result as it waits in the output queue.
  typedef struct packed {
    logic               ready_res;
    logic               match;
    logic [POS_W-1:0]   start_position;
    logic [COUNT_W-1:0] match_count;
  } result_t;

endpackage

### hw/rtl/kmpsm_cell.sv
// One matcher cell: a pattern byte and its prefix-match flag.
module kmpsm_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       step_i,
  input  logic                       clr_i,
  input  logic [kmpsm_pkg::BYTE_W-1:0] byte_i,
  input  logic                       prev_hit_i,
  output logic                       hit_d_o,
  output logic                       hit_q_o
);
  import kmpsm_pkg::*;

  logic [BYTE_W-1:0] pat_q;
  logic              hit_q;

  // The pattern byte is captured when this cell is the next one to fill.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= byte_i;
    end
  end

  // The prefix ending here matches if the shorter one matched a byte earlier.
  assign hit_d_o = (pat_q == byte_i) && prev_hit_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (clr_i) begin
      hit_q <= 1'b0;
    end else if (step_i) begin
      hit_q <= hit_d_o;
    end
  end

  assign hit_q_o = hit_q;

endmodule

### hw/rtl/kmpsm_out_fifo.sv
// Two-entry result queue between the cell row and the output channel.
module kmpsm_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kmpsm_pkg::result_t  data_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output kmpsm_pkg::result_t  data_o
);
  import kmpsm_pkg::*;

  result_t     head_q, tail_q;
  logic [1:0]  cnt_q, cnt_d;

  // Occupancy; the producer never pushes into a full queue.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Entry storage: the head moves up on a pop, new data lands behind.
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      if (push_i && cnt_q == 2'd1) begin
        head_q <= data_i;
      end else begin
        head_q <= tail_q;
      end
      if (push_i && cnt_q == 2'd2) begin
        tail_q <= data_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        head_q <= data_i;
      end else begin
        tail_q <= data_i;
      end
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = head_q;

endmodule

### hw/rtl/kmp_stream_matcher_unit.sv
// Top level of the KMP stream matcher: cell row, control and result queue.
//
// Use: requests arrive on the input channel (in_valid_i / in_stall_o) with a
// mode and a byte. Load requests fill the pattern one byte at a time until
// pattern_length bytes are held; further loads are dropped. Each text request
// gives exactly one result on the output channel (out_valid_o / out_stall_i):
// ready flag, match flag, start position of the match and the running count.
// Restart and clear requests give no result. The pattern length is written
// on the configuration channel (cfg_valid_i / cfg_ready_o) while idle.
// Results are registered in the result queue before they reach the output channel.
// Throughput: one request per cycle while in_stall_o is low; every cell compares
// the text byte in the same cycle, and its registered prefix flag feeds the next cell.
// A two-entry result queue lets a request be taken while one result waits;
// whenever two results wait, in_stall_o is raised.
// Reset clears the pattern count, match flags, position and count and sets
// the pattern length to one; the queue empties at once.
`include "kmp_stream_matcher_unit_assert.svh"

module kmp_stream_matcher_unit #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kmpsm_pkg::PLEN_W-1:0]  cfg_pattern_length_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_mode_i,
  input  logic [kmpsm_pkg::BYTE_W-1:0]  in_byte_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_ready_res_o,
  output logic                          out_match_o,
  output logic [kmpsm_pkg::POS_W-1:0]   out_start_position_o,
  output logic [kmpsm_pkg::COUNT_W-1:0] out_match_count_o
);
  import kmpsm_pkg::*;

  // The length register cannot exceed 127, so no more cells are useful.
  localparam int unsigned PLEN_MAX = (1 << PLEN_W) - 1;
  localparam int unsigned NCELL = (MAX_PATTERN < PLEN_MAX) ? MAX_PATTERN : PLEN_MAX;
  localparam int unsigned CW    = $clog2(NCELL + 1);
  localparam int unsigned IW    = $clog2(NCELL);

  logic [PLEN_W-1:0]  plen_q;
  logic [CW-1:0]      loaded_q;
  logic [POS_W-1:0]   pos_q;
  logic [COUNT_W-1:0] cnt_q, cnt_inc;
  logic [PLEN_W-1:0]  len, len_m1;
  logic               pat_ready;
  logic               in_acc, cfg_we, fifo_full;
  logic               load_en, text_step, restart, clear_pat, push;
  logic [NCELL-1:0]   hit_d, hit_q, cell_load;
  logic               hit;
  logic [POS_W:0]     pos_p1;
  logic [POS_W-1:0]   start;
  mode_e              mode;
  result_t            res, head;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = fifo_full;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign mode        = mode_e'(in_mode_i);

  // Effective pattern length: zero acts as one, clamp to the cell count.
  always_comb begin
    if (plen_q == '0) begin
      len = PLEN_W'(1);
    end else if (plen_q > PLEN_W'(NCELL)) begin
      len = PLEN_W'(NCELL);
    end else begin
      len = plen_q;
    end
  end

  assign len_m1    = len - PLEN_W'(1);
  assign pat_ready = (PLEN_W'(loaded_q) >= len);

  // Request decode.
  always_comb begin
    load_en   = 1'b0;
    text_step = 1'b0;
    restart   = 1'b0;
    clear_pat = 1'b0;
    push      = 1'b0;
    if (in_acc) begin
      unique case (mode)
        MODE_LOAD: begin
          load_en = !pat_ready;
        end
        MODE_TEXT: begin
          text_step = pat_ready;
          push      = 1'b1;
        end
        MODE_RESTART: begin
          restart = 1'b1;
        end
        MODE_CLEAR: begin
          restart   = 1'b1;
          clear_pat = 1'b1;
        end
        default: begin
          load_en = 1'b0;
        end
      endcase
    end
  end

  // Row of cells; the first one always has the empty prefix behind it.
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    assign cell_load[j] = load_en && (loaded_q == CW'(j));
    kmpsm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (cell_load[j]),
      .step_i     (text_step),
      .clr_i      (restart || cfg_we),
      .byte_i     (in_byte_value_i),
      .prev_hit_i ((j == 0) ? 1'b1 : hit_q[(j == 0) ? 0 : j - 1]),
      .hit_d_o    (hit_d[j]),
      .hit_q_o    (hit_q[j])
    );
  end

  // A full match ends here when the cell at the last pattern byte hits.
  assign hit     = pat_ready && hit_d[IW'(len_m1)];
  assign cnt_inc = (hit && cnt_q != '1) ? cnt_q + COUNT_W'(1) : cnt_q;
  assign pos_p1  = {1'b0, pos_q} + (POS_W + 1)'(1);
  assign start   = (pos_p1 >= (POS_W + 1)'(len)) ?
                   POS_W'(pos_p1 - (POS_W + 1)'(len)) : '0;

  // Result as it enters the queue.
  always_comb begin
    res.ready_res      = pat_ready;
    res.match          = hit;
    res.start_position = hit ? start : '0;
    res.match_count    = cnt_inc;
  end

  // Pattern length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= PLEN_W'(1);
    end else if (cfg_we) begin
      plen_q <= cfg_pattern_length_i;
    end
  end

  // Loaded byte count, text position and match count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (clear_pat) begin
        loaded_q <= '0;
      end else if (load_en) begin
        loaded_q <= loaded_q + CW'(1);
      end
      if (restart) begin
        pos_q <= '0;
        cnt_q <= '0;
      end else if (text_step) begin
        cnt_q <= cnt_inc;
        if (pos_q < POS_CAP) begin
          pos_q <= pos_q + POS_W'(1);
        end
      end
    end
  end

  kmpsm_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .pop_i   (out_valid_o && !out_stall_i),
    .full_o  (fifo_full),
    .valid_o (out_valid_o),
    .data_o  (head)
  );

  assign out_ready_res_o      = head.ready_res;
  assign out_match_o          = head.match;
  assign out_start_position_o = head.start_position;
  assign out_match_count_o    = head.match_count;

  // After a restart or a length write no prefix may still be marked.
  `KMPSM_ASSERT(a_clr_flags, clk_i, rst_ni, (restart || cfg_we) |=> (hit_q == '0))
  // A result given before the pattern is complete never reports a match.
  `KMPSM_ASSERT(a_unready_nomatch, clk_i, rst_ni,
                (out_valid_o && !out_ready_res_o) |-> !out_match_o)
  // A reported match is always counted.
  `KMPSM_ASSERT(a_match_counted, clk_i, rst_ni,
                (out_valid_o && out_match_o) |-> (out_match_count_o != '0))
  // The pattern never holds more bytes than there are cells.
  `KMPSM_ASSERT_ALWAYS(a_loaded_bound, clk_i, (loaded_q <= CW'(NCELL)))

endmodule

### verif/tb.sv
// Self-checking testbench for the KMP stream matcher top level.
`timescale 1ns / 100ps

module tb;
  import kmpsm_pkg::*;

  localparam int unsigned PATTERN_DEPTH    = 64;
  localparam int unsigned CLK_PERIOD       = 8;
  localparam int unsigned ITEM_TARGET      = 1700;
  localparam int unsigned DENSE_TEXT_ITEMS = 200;
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned DRAIN_CYCLES     = 16;
  localparam int unsigned LIMIT_CYCLES     = 3000000;

  // One line of the directed sequence: either a length write or a request.
  typedef struct packed {
    bit          is_cfg;
    mode_e       mode;
    logic [7:0]  val;
    bit          typed;
    result_t     want;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;
  localparam int unsigned DIR_ROWS = 30;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b0, MODE_TEXT,    8'h00, 1'b1, '{1'b0, 1'b0, 16'd0, 16'd0}},
    '{1'b0, MODE_LOAD,    8'hFF, 1'b0, NO_RESULT},
    '{1'b0, MODE_LOAD,    8'h00, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'hFF, 1'b1, '{1'b1, 1'b1, 16'd0, 16'd1}},
    '{1'b0, MODE_TEXT,    8'h00, 1'b1, '{1'b1, 1'b0, 16'd0, 16'd1}},
    '{1'b0, MODE_TEXT,    8'hFF, 1'b1, '{1'b1, 1'b1, 16'd2, 16'd2}},
    '{1'b0, MODE_RESTART, 8'h5A, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'hFF, 1'b1, '{1'b1, 1'b1, 16'd0, 16'd1}},
    '{1'b0, MODE_CLEAR,   8'hA5, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'hFF, 1'b1, '{1'b0, 1'b0, 16'd0, 16'd0}},
    '{1'b1, MODE_LOAD,    8'd3,  1'b0, NO_RESULT},
    '{1'b0, MODE_LOAD,    8'h61, 1'b0, NO_RESULT},
    '{1'b0, MODE_LOAD,    8'h62, 1'b0, NO_RESULT},
    '{1'b0, MODE_LOAD,    8'h61, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h61, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h62, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h61, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h62, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h61, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h80, 1'b0, NO_RESULT},
    '{1'b1, MODE_LOAD,    8'd0,  1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h61, 1'b0, NO_RESULT},
    '{1'b1, MODE_LOAD,    8'd127, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h7F, 1'b0, NO_RESULT},
    '{1'b0, MODE_LOAD,    8'h40, 1'b0, NO_RESULT},
    '{1'b1, MODE_LOAD,    8'd2,  1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h61, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h62, 1'b0, NO_RESULT},
    '{1'b0, MODE_RESTART, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, MODE_TEXT,    8'h62, 1'b0, NO_RESULT}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [PLEN_W-1:0]   cfg_pattern_length_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          in_mode_i;
  logic [BYTE_W-1:0]   in_byte_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                out_ready_res_o;
  logic                out_match_o;
  logic [POS_W-1:0]    out_start_position_o;
  logic [COUNT_W-1:0]  out_match_count_o;

  // Shadow of the matcher state, advanced on every accepted request.
  logic [7:0]          pat_mem [PATTERN_DEPTH];
  logic [5:0]          border_mem [PATTERN_DEPTH];
  logic [PLEN_W-1:0]   plen_q;
  int unsigned         loaded_q;
  int unsigned         border_len_q;
  int unsigned         match_len_q;
  logic [POS_W-1:0]    text_pos_q;
  logic [COUNT_W-1:0]  hit_count_q;

  result_t             pending_results [$];
  int unsigned         fail_count;
  int unsigned         cycle_count;
  int unsigned         items_sent;
  int unsigned         hold_offs_asked;
  int unsigned         hold_offs_done;
  int unsigned         burst_left;
  int unsigned         burst_max;
  int unsigned         gap_max;
  logic [7:0]          alpha_base;
  int unsigned         alpha_span;

  kmp_stream_matcher_unit #(
    .MAX_PATTERN (PATTERN_DEPTH)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_pattern_length_i (cfg_pattern_length_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_mode_i            (in_mode_i),
    .in_byte_value_i      (in_byte_value_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_ready_res_o      (out_ready_res_o),
    .out_match_o          (out_match_o),
    .out_start_position_o (out_start_position_o),
    .out_match_count_o    (out_match_count_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Pattern length as the matcher uses it: zero acts as one, and the
  // value is capped at the pattern depth.
  function automatic int unsigned active_len();
    int unsigned len;
    len = plen_q;
    if (len < 1) len = 1;
    if (len > PATTERN_DEPTH) len = PATTERN_DEPTH;
    return len;
  endfunction

  // Longest pattern prefix after extending matched length k by one byte,
  // falling back through the border table on a mismatch.
  function automatic int unsigned extend_match(int unsigned k, logic [7:0] val);
    while (k > 0 && pat_mem[k] != val) k = border_mem[k-1];
    if (pat_mem[k] == val) k++;
    return k;
  endfunction

  // Applies one accepted request to the shadow state. A text request yields
  // the result it should produce; ignored loads are flagged as not counting.
  function automatic void kmp_advance(input mode_e m, input logic [7:0] val,
                                      output bit has_res, output bit counts,
                                      output result_t res);
    int unsigned len;
    int unsigned q;
    int unsigned pos;
    len     = active_len();
    has_res = 1'b0;
    counts  = 1'b1;
    res     = '0;
    case (m)
      MODE_LOAD: begin
        if (loaded_q >= len) begin
          counts = 1'b0;
        end else begin
          border_len_q = (loaded_q == 0) ? 0 : extend_match(border_len_q, val);
          pat_mem[loaded_q]    = val;
          border_mem[loaded_q] = 6'(border_len_q);
          loaded_q++;
        end
      end
      MODE_RESTART, MODE_CLEAR: begin
        match_len_q = 0;
        text_pos_q  = '0;
        hit_count_q = '0;
        if (m == MODE_CLEAR) begin
          loaded_q     = 0;
          border_len_q = 0;
        end
      end
      MODE_TEXT: begin
        has_res = 1'b1;
        if (loaded_q < len) begin
          res.match_count = hit_count_q;
        end else begin
          q = (match_len_q >= len) ? 0 : match_len_q;
          q = extend_match(q, val);
          res.ready_res = 1'b1;
          if (q >= len) begin
            res.match = 1'b1;
            pos = text_pos_q;
            res.start_position = (pos + 1 >= len) ? POS_W'(pos + 1 - len) : '0;
            if (hit_count_q != '1) hit_count_q++;
            q = border_mem[len-1];
          end
          match_len_q = q;
          if (text_pos_q < POS_CAP) text_pos_q++;
          res.match_count = hit_count_q;
        end
      end
      default: ;
    endcase
  endfunction

  // A byte from the small alphabet of the current phase.
  function automatic logic [7:0] pick_symbol();
    return alpha_base + 8'($urandom_range(0, alpha_span - 1));
  endfunction

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Offers one request until it is taken, then records what it should yield.
  task automatic send_request(input mode_e m, input logic [7:0] val,
                              input bit typed, input result_t want);
    bit      has_res;
    bit      counts;
    result_t res;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    in_mode_i       <= m;
    in_byte_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    kmp_advance(m, val, has_res, counts, res);
    if (has_res) pending_results.push_back(typed ? want : res);
    if (counts) items_sent++;
  endtask

  // Sender pacing: bursts of back-to-back requests separated by gaps.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, burst_max);
      gap = $urandom_range(1, gap_max);
      drop_valid();
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Length writes happen only once the matcher has drained.
  task automatic write_length(input logic [PLEN_W-1:0] len);
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i          <= 1'b1;
    cfg_pattern_length_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    plen_q      = len;
    match_len_q = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                 $time, out_ready_res_o, out_match_o, out_start_position_o,
                 out_match_count_o);
      end else begin
        want = pending_results.pop_front();
        check_field("ready_res", want.ready_res, out_ready_res_o);
        check_field("match", want.match, out_match_o);
        check_field("start_position", want.start_position, out_start_position_o);
        check_field("match_count", want.match_count, out_match_count_o);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL kmp_stream_matcher_unit");
      $finish;
    end
  end

  // Receiver: open and stalled stretches of random length, plus long
  // hold-offs on request so that the result queue fills and input stalls.
  initial begin : receiver
    int unsigned open_len;
    int unsigned shut_len;
    out_stall_i = 1'b0;
    forever begin
      if (hold_offs_asked != hold_offs_done) begin
        hold_offs_done++;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      open_len = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16);
      shut_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (open_len) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat (shut_len) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed table, random phases, then a dense run of
  // matches under a long receiver hold-off.
  initial begin : stimulus
    logic [PLEN_W-1:0] len_val;
    int unsigned       shape;
    int                text_left;
    int unsigned       dice;
    int unsigned       copy_len;
    rst_ni               = 1'b0;
    cfg_valid_i          = 1'b0;
    cfg_pattern_length_i = '0;
    in_valid_i           = 1'b0;
    in_mode_i            = MODE_LOAD;
    in_byte_value_i      = '0;
    for (int i = 0; i < PATTERN_DEPTH; i++) begin
      pat_mem[i]    = '0;
      border_mem[i] = '0;
    end
    plen_q          = 7'd1;
    loaded_q        = 0;
    border_len_q    = 0;
    match_len_q     = 0;
    text_pos_q      = '0;
    hit_count_q     = '0;
    fail_count      = 0;
    cycle_count     = 0;
    items_sent      = 0;
    hold_offs_asked = 0;
    hold_offs_done  = 0;
    burst_left      = 0;
    burst_max       = 30;
    gap_max         = 10;
    alpha_base      = '0;
    alpha_span      = 1;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].is_cfg) begin
        write_length(DIR_TABLE[r].val[PLEN_W-1:0]);
      end else begin
        send_request(DIR_TABLE[r].mode, DIR_TABLE[r].val, DIR_TABLE[r].typed,
                     DIR_TABLE[r].want);
        pace();
      end
    end

    // Random phases: mostly a fresh pattern followed by text built partly
    // from copies of it, with restarts, broken loads and noise mixed in.
    hold_offs_asked++;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       len_val = 7'd0;
        1:       len_val = 7'd1;
        2:       len_val = 7'd64;
        3:       len_val = 7'($urandom_range(65, 127));
        4, 5:    len_val = 7'($urandom_range(2, 4));
        default: len_val = 7'($urandom_range(1, 12));
      endcase
      write_length(len_val);
      alpha_base = 8'($urandom);
      alpha_span = $urandom_range(1, 3);
      shape      = $urandom_range(0, 9);
      if (shape < 8) begin
        send_request(MODE_CLEAR, 8'($urandom), 1'b0, NO_RESULT);
        pace();
        repeat (active_len() + ((shape == 0) ? $urandom_range(1, 2) : 0)) begin
          send_request(MODE_LOAD, pick_symbol(), 1'b0, NO_RESULT);
          pace();
        end
      end else if (shape == 8) begin
        repeat ($urandom_range(0, 6)) begin
          send_request(MODE_LOAD, pick_symbol(), 1'b0, NO_RESULT);
          pace();
        end
      end else begin
        send_request(MODE_RESTART, 8'($urandom), 1'b0, NO_RESULT);
        pace();
      end
      text_left = $urandom_range(8, 60);
      while (text_left > 0) begin
        dice = $urandom_range(0, 99);
        if (dice < 3) begin
          send_request(MODE_RESTART, 8'($urandom), 1'b0, NO_RESULT);
          pace();
          text_left--;
        end else if (dice < 6) begin
          send_request(mode_e'($urandom_range(0, 3)), 8'($urandom), 1'b0, NO_RESULT);
          pace();
          text_left--;
        end else if (dice < 40 && loaded_q >= active_len()) begin
          // Replay a prefix of the pattern, often the whole of it.
          copy_len = $urandom_range(0, 1) ? active_len() : $urandom_range(1, active_len());
          for (int i = 0; i < copy_len; i++) begin
            send_request(MODE_TEXT, pat_mem[i], 1'b0, NO_RESULT);
            pace();
          end
          text_left -= copy_len;
        end else begin
          send_request(MODE_TEXT, pick_symbol(), 1'b0, NO_RESULT);
          pace();
          text_left--;
        end
      end
    end

    // Dense run: a one-byte pattern that nearly every text byte hits, sent
    // in long bursts while the receiver holds off, so the queue fills up.
    write_length(7'd1);
    send_request(MODE_CLEAR, 8'h00, 1'b0, NO_RESULT);
    pace();
    send_request(MODE_LOAD, 8'h5A, 1'b0, NO_RESULT);
    pace();
    hold_offs_asked++;
    gap_max   = 1;
    burst_max = 400;
    for (int n = 0; n < DENSE_TEXT_ITEMS; n++) begin
      send_request(MODE_TEXT, ((n % 64) == 40) ? 8'hA5 : 8'h5A, 1'b0, NO_RESULT);
      pace();
    end
    send_request(MODE_RESTART, 8'hFF, 1'b0, NO_RESULT);
    pace();
    repeat (3) begin
      send_request(MODE_TEXT, 8'h5A, 1'b0, NO_RESULT);
      pace();
    end

    // Drain and report.
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS kmp_stream_matcher_unit");
    end else begin
      $display("FAIL kmp_stream_matcher_unit");
    end
    $finish;
  end

endmodule
